>>> hw/rtl/blpg_pkg.sv
// ----------------------------------------------------------------------------
// blpg_pkg - shared types for the Bresenham line pixel generator
// Coordinate widths, command codes and the line walk state record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blpg_pkg;

  localparam int unsigned CoordW = 9;
  localparam int unsigned YW     = 8;
  localparam int unsigned ColorW = 16;
  localparam int unsigned ErrW   = CoordW + 1;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                     steep;
    logic [CoordW-1:0]        major_pos;
    logic [CoordW-1:0]        major_end;
    logic [CoordW-1:0]        minor_pos;
    logic signed [ErrW-1:0]   error_term;
    logic [CoordW-1:0]        major_delta;
    logic [CoordW-1:0]        minor_delta;
    logic                     minor_up;
    logic [ColorW-1:0]        held_color;
  } line_t;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [YW-1:0]     pixel_y;
    logic [ColorW-1:0] pixel_color;
    logic              last_pixel;
  } pixel_t;

endpackage

>>> hw/rtl/blpg_cmd_if.sv
// ----------------------------------------------------------------------------
// blpg_cmd_if - command channel
// Valid/ready channel carrying one start or step command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface blpg_cmd_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [blpg_pkg::CoordW-1:0]    start_x;
  logic [blpg_pkg::YW-1:0]        start_y;
  logic [blpg_pkg::CoordW-1:0]    end_x;
  logic [blpg_pkg::YW-1:0]        end_y;
  logic [blpg_pkg::ColorW-1:0]    pen_color;

  modport source (
    output valid, command, start_x, start_y, end_x, end_y, pen_color,
    input  ready
  );

  modport sink (
    input  valid, command, start_x, start_y, end_x, end_y, pen_color,
    output ready
  );
endinterface

>>> hw/rtl/blpg_pix_if.sv
// ----------------------------------------------------------------------------
// blpg_pix_if - pixel channel
// Valid/ready channel carrying one emitted pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface blpg_pix_if;
  logic                           valid;
  logic                           ready;
  logic [blpg_pkg::CoordW-1:0]    pixel_x;
  logic [blpg_pkg::YW-1:0]        pixel_y;
  logic [blpg_pkg::ColorW-1:0]    pixel_color;
  logic                           last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
    output ready
  );
endinterface

>>> hw/rtl/blpg_setup.sv
// ----------------------------------------------------------------------------
// blpg_setup - line setup
// Derives the walk state of a new line from its two endpoints and color.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blpg_setup (
  input  logic [blpg_pkg::CoordW-1:0] start_x_i,
  input  logic [blpg_pkg::YW-1:0]     start_y_i,
  input  logic [blpg_pkg::CoordW-1:0] end_x_i,
  input  logic [blpg_pkg::YW-1:0]     end_y_i,
  input  logic [blpg_pkg::ColorW-1:0] color_i,
  output blpg_pkg::line_t             line_o
);

  localparam int unsigned CW = blpg_pkg::CoordW;
  localparam int unsigned EW = blpg_pkg::ErrW;

  logic [CW-1:0] ya, yb;
  logic          x_gt, y_gt, steep, swap;
  logic [CW-1:0] adx, ady;
  logic [CW-1:0] maj0, maj1, min0, min1;
  logic [CW-1:0] minor_pos, minor_end, major_delta;

  assign ya   = CW'(start_y_i);
  assign yb   = CW'(end_y_i);
  assign x_gt = start_x_i > end_x_i;
  assign y_gt = ya > yb;
  assign adx  = x_gt ? (start_x_i - end_x_i) : (end_x_i - start_x_i);
  assign ady  = y_gt ? (ya - yb) : (yb - ya);

  // Steep lines walk along y; order so the major coordinate increases.
  assign steep = ady > adx;
  assign swap  = steep ? y_gt : x_gt;

  assign maj0 = steep ? ya : start_x_i;
  assign maj1 = steep ? yb : end_x_i;
  assign min0 = steep ? start_x_i : ya;
  assign min1 = steep ? end_x_i : yb;

  assign minor_pos   = swap ? min1 : min0;
  assign minor_end   = swap ? min0 : min1;
  assign major_delta = steep ? ady : adx;

  always_comb begin
    line_o.steep       = steep;
    line_o.major_pos   = swap ? maj1 : maj0;
    line_o.major_end   = swap ? maj0 : maj1;
    line_o.minor_pos   = minor_pos;
    line_o.major_delta = major_delta;
    line_o.minor_delta = steep ? adx : ady;
    line_o.minor_up    = minor_pos < minor_end;
    // Start the error at minus half the major delta.
    line_o.error_term  = $signed(EW'(0) - EW'(major_delta >> 1));
    line_o.held_color  = color_i;
  end

endmodule

>>> hw/rtl/blpg_step.sv
// ----------------------------------------------------------------------------
// blpg_step - one Bresenham step
// Forms the current pixel and the walk state after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blpg_step (
  input  blpg_pkg::line_t  line_i,
  output blpg_pkg::pixel_t pixel_o,
  output blpg_pkg::line_t  line_o
);

  localparam int unsigned CW = blpg_pkg::CoordW;
  localparam int unsigned EW = blpg_pkg::ErrW;

  logic signed [EW:0]   err_sum;
  logic signed [EW:0]   err_adj;
  logic [CW-1:0]        py_full;

  assign err_sum = $signed({line_i.error_term[EW-1], line_i.error_term})
                 + $signed({2'b00, line_i.minor_delta});
  assign err_adj = err_sum - $signed({2'b00, line_i.major_delta});
  assign py_full = line_i.steep ? line_i.major_pos : line_i.minor_pos;

  always_comb begin
    pixel_o.pixel_x     = line_i.steep ? line_i.minor_pos : line_i.major_pos;
    pixel_o.pixel_y     = py_full[blpg_pkg::YW-1:0];
    pixel_o.pixel_color = line_i.held_color;
    pixel_o.last_pixel  = line_i.major_pos == line_i.major_end;

    line_o           = line_i;
    line_o.major_pos = line_i.major_pos + CW'(1);
    // Advance the minor axis once the error crosses zero.
    if (!err_sum[EW]) begin
      line_o.minor_pos  = line_i.minor_up ? (line_i.minor_pos + CW'(1))
                                          : (line_i.minor_pos - CW'(1));
      line_o.error_term = err_adj[EW-1:0];
    end else begin
      line_o.error_term = err_sum[EW-1:0];
    end
  end

endmodule

>>> hw/rtl/bresenham_line_pixel_generator.sv
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator - integer line rasterizer
// Path: a step's pixel goes through the input register, then the pixel register,
// before it is offered. Start and step logic is one short pass.
// Throughput: one command per cycle unless a held pixel stalls a step.
// Reset: clears the busy flag and both valid flags; line state is loaded
// by the first start command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bresenham_line_pixel_generator (
  input  logic         clk_i,
  input  logic         rst_ni,
  blpg_cmd_if.sink     cmd_i,
  blpg_pix_if.source   pix_o
);

  // Input register: holds one accepted command.
  logic                           in_valid_q;
  logic                           in_cmd_q;
  logic [blpg_pkg::CoordW-1:0]    in_sx_q, in_ex_q;
  logic [blpg_pkg::YW-1:0]        in_sy_q, in_ey_q;
  logic [blpg_pkg::ColorW-1:0]    in_color_q;

  // Walk state.
  logic                           busy_q, busy_d;
  blpg_pkg::line_t                line_q, line_d;

  // Pixel output register.
  logic                           out_valid_q, out_valid_d;
  blpg_pkg::pixel_t               out_pix_q;

  blpg_pkg::line_t                setup_line;
  blpg_pkg::line_t                step_line;
  blpg_pkg::pixel_t               step_pix;

  logic is_start, is_step, makes_pixel, out_free, in_fire, in_ready;

  blpg_setup u_setup (
    .start_x_i (in_sx_q),
    .start_y_i (in_sy_q),
    .end_x_i   (in_ex_q),
    .end_y_i   (in_ey_q),
    .color_i   (in_color_q),
    .line_o    (setup_line)
  );

  blpg_step u_step (
    .line_i  (line_q),
    .pixel_o (step_pix),
    .line_o  (step_line)
  );

  assign is_start    = in_valid_q && (in_cmd_q == blpg_pkg::CMD_START);
  assign is_step     = in_valid_q && (in_cmd_q == blpg_pkg::CMD_STEP);
  // Only a step on a live line yields a pixel; a step while idle just retires.
  assign makes_pixel = is_step && busy_q;
  assign out_free    = !out_valid_q || pix_o.ready;
  // Retire the held command unless its pixel has nowhere to go.
  assign in_fire     = in_valid_q && (!makes_pixel || out_free);
  assign in_ready    = !in_valid_q || in_fire;

  assign cmd_i.ready = in_ready;

  always_comb begin
    busy_d = busy_q;
    line_d = line_q;
    if (in_fire && is_start) begin
      // A start always wins: drop any line in progress.
      busy_d = 1'b1;
      line_d = setup_line;
    end else if (in_fire && makes_pixel) begin
      busy_d = !step_pix.last_pixel;
      line_d = step_line;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && makes_pixel) begin
      out_valid_d = 1'b1;
    end else if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= cmd_i.valid;
      end
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && in_ready) begin
      in_cmd_q   <= cmd_i.command;
      in_sx_q    <= cmd_i.start_x;
      in_sy_q    <= cmd_i.start_y;
      in_ex_q    <= cmd_i.end_x;
      in_ey_q    <= cmd_i.end_y;
      in_color_q <= cmd_i.pen_color;
    end
    line_q <= line_d;
    if (in_fire && makes_pixel) begin
      out_pix_q <= step_pix;
    end
  end

  assign pix_o.valid       = out_valid_q;
  assign pix_o.pixel_x     = out_pix_q.pixel_x;
  assign pix_o.pixel_y     = out_pix_q.pixel_y;
  assign pix_o.pixel_color = out_pix_q.pixel_color;
  assign pix_o.last_pixel  = out_pix_q.last_pixel;

  // The last pixel of a line ends the walk.
  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && makes_pixel && step_pix.last_pixel) |=> !busy_q)
    else $error("walk still busy after last pixel");

  // A start leaves the block walking a line.
  a_start_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_start) |=> busy_q)
    else $error("start did not begin a line");

  // A fresh pixel only comes from a live line.
  a_pixel_needs_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q))
    else $error("pixel produced while idle");

  // Walk invariant: error stays in [-major_delta, 0]; checked: error <= 0, minor delta <= major.
  a_error_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (line_q.error_term <= 0)
               && (line_q.minor_delta <= line_q.major_delta))
    else $error("error term out of range");

endmodule
